/* sv/soep_pkg.sv */
`default_nettype none

package soep_pkg;

  localparam int MAX_ELECTRONS = 64;
  localparam int NUM_ORBITALS  = 256;

  localparam int ORB_W    = 8;
  localparam int OP_W     = 3;
  localparam int PHASE_W  = 2;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = $clog2(MAX_ELECTRONS);
  localparam int LEN_W    = $clog2(MAX_ELECTRONS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR        = 3'd0,
    OP_APPEND       = 3'd1,
    OP_READ         = 3'd2,
    OP_PHASE_SINGLE = 3'd3,
    OP_PHASE_DOUBLE = 3'd4,
    OP_EXCITE_SINGLE = 3'd5,
    OP_EXCITE_DOUBLE = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_ORDER = 3'd2,
    ST_HOLE  = 3'd3,
    ST_PART  = 3'd4,
    ST_INDEX = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PAIR_AB = 2'd0,
    PAIR_CD = 2'd1,
    PAIR_BA = 2'd2
  } pair_t;

  typedef enum logic {
    RD_ENTRY = 1'b0,
    RD_LAST  = 1'b1
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    len_clear;
    logic    append_we;
    logic    rd_issue;
    rd_sel_t rd_sel;
    logic    orb_we;
    logic    scan_start;
    pair_t   pair_sel;
    logic    scan_issue;
    logic    phase_we;
    logic    shift_init;
    logic    shift_issue;
    logic    place_we;
    logic    status_we;
    status_t status_val;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic a_bad;
    logic len_zero;
    logic a_in_range;
    logic order_bad;
    logic scan_done;
    logic part_bad;
    logic hole_found;
    logic part_found;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/soep_in_if.sv */
`default_nettype none

interface soep_in_if import soep_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [ORB_W-1:0] orbital_a;
  logic [ORB_W-1:0] orbital_b;
  logic [ORB_W-1:0] orbital_c;
  logic [ORB_W-1:0] orbital_d;

  modport source (output valid, opcode, orbital_a, orbital_b, orbital_c, orbital_d,
                  input ready);
  modport sink (input valid, opcode, orbital_a, orbital_b, orbital_c, orbital_d,
                output ready);
endinterface

`default_nettype wire

/* sv/soep_out_if.sv */
`default_nettype none

interface soep_out_if import soep_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase;
  logic [ORB_W-1:0]          orbital_out;
  logic [COUNT_W-1:0]        occupied_count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, phase, orbital_out, occupied_count, status,
                  input ready);
  modport sink (input valid, phase, orbital_out, occupied_count, status,
                output ready);
endinterface

`default_nettype wire

/* sv/soep_ctrl.sv */
`default_nettype none

module soep_ctrl import soep_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DISPATCH  = 9'b000000010,
    S_RD_WAIT   = 9'b000000100,
    S_APP_CHECK = 9'b000001000,
    S_SCAN      = 9'b000010000,
    S_EVAL      = 9'b000100000,
    S_SHIFT     = 9'b001000000,
    S_PLACE     = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    STAGE_FIRST  = 2'd0,
    STAGE_SECOND = 2'd1,
    STAGE_UNDO   = 2'd2
  } stage_t;

  state_t state, state_next;
  stage_t stage, stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stage <= STAGE_FIRST;
    end else begin
      state <= state_next;
      stage <= stage_next;
    end
  end

  always_comb begin
    status_t err_code;
    logic    err;
    cmd        = '0;
    state_next = state;
    stage_next = stage;
    in_ready   = 1'b0;
    err        = 1'b0;
    err_code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        unique case (sts.op)
          OP_CLEAR: cmd.len_clear = 1'b1;
          OP_APPEND: begin
            priority if (sts.full) begin
              cmd.status_we  = 1'b1;
              cmd.status_val = ST_FULL;
            end else if (sts.a_bad) begin
              cmd.status_we  = 1'b1;
              cmd.status_val = ST_INDEX;
            end else if (sts.len_zero) begin
              cmd.append_we = 1'b1;
            end else begin
              cmd.rd_issue = 1'b1;
              cmd.rd_sel   = RD_LAST;
              state_next   = S_APP_CHECK;
            end
          end
          OP_READ: begin
            if (sts.a_in_range) begin
              cmd.rd_issue = 1'b1;
              cmd.rd_sel   = RD_ENTRY;
              state_next   = S_RD_WAIT;
            end else begin
              cmd.status_we  = 1'b1;
              cmd.status_val = ST_INDEX;
            end
          end
          OP_PHASE_SINGLE, OP_PHASE_DOUBLE: begin
            cmd.scan_start = 1'b1;
            cmd.pair_sel   = PAIR_AB;
            state_next     = S_SCAN;
          end
          OP_EXCITE_SINGLE, OP_EXCITE_DOUBLE: begin
            cmd.scan_start = 1'b1;
            cmd.pair_sel   = PAIR_AB;
            stage_next     = STAGE_FIRST;
            state_next     = S_SCAN;
          end
          default: ;
        endcase
      end
      S_RD_WAIT: begin
        cmd.orb_we = 1'b1;
        state_next = S_FINISH;
      end
      S_APP_CHECK: begin
        if (sts.order_bad) begin
          cmd.status_we  = 1'b1;
          cmd.status_val = ST_ORDER;
        end else begin
          cmd.append_we = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_EVAL;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_EVAL: begin
        if (sts.op == OP_PHASE_SINGLE || sts.op == OP_PHASE_DOUBLE) begin
          cmd.phase_we = 1'b1;
          state_next   = S_FINISH;
        end else begin
          priority if (sts.part_bad) begin
            err      = 1'b1;
            err_code = ST_INDEX;
          end else if (!sts.hole_found) begin
            err      = 1'b1;
            err_code = ST_HOLE;
          end else if (sts.part_found) begin
            err      = 1'b1;
            err_code = ST_PART;
          end else begin
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end
          if (err) begin
            cmd.status_we  = 1'b1;
            cmd.status_val = err_code;
            if (stage == STAGE_SECOND) begin
              // undo the first pair by swapping its roles
              cmd.scan_start = 1'b1;
              cmd.pair_sel   = PAIR_BA;
              stage_next     = STAGE_UNDO;
              state_next     = S_SCAN;
            end else begin
              state_next = S_FINISH;
            end
          end
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          state_next = S_PLACE;
        end else begin
          cmd.shift_issue = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.place_we = 1'b1;
        if (sts.op == OP_EXCITE_DOUBLE && stage == STAGE_FIRST) begin
          cmd.scan_start = 1'b1;
          cmd.pair_sel   = PAIR_CD;
          stage_next     = STAGE_SECOND;
          state_next     = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* sv/soep_dp.sv */
`default_nettype none

module soep_dp import soep_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [OP_W-1:0]           opcode,
  input  wire logic [ORB_W-1:0]          orbital_a,
  input  wire logic [ORB_W-1:0]          orbital_b,
  input  wire logic [ORB_W-1:0]          orbital_c,
  input  wire logic [ORB_W-1:0]          orbital_d,
  input  wire cmd_t                      cmd,
  output sts_t                           sts,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [PHASE_W-1:0]      phase,
  output logic [ORB_W-1:0]               orbital_out,
  output logic [COUNT_W-1:0]             occupied_count,
  output logic [STATUS_W-1:0]            status
);

  logic [ORB_W-1:0] mem [MAX_ELECTRONS];

  op_t                       op;
  logic [ORB_W-1:0]          a, b, c, d;
  logic [ORB_W-1:0]          hole, part;
  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          ptr;
  logic [ORB_W-1:0]          rdata;
  logic                      sval;
  logic [IDX_W-1:0]          sidx;
  logic                      hole_found, part_found;
  logic [IDX_W-1:0]          ih;
  logic [LEN_W-1:0]          lt_cnt;
  logic                      par1, par2;
  logic                      wb_valid;
  logic [IDX_W-1:0]          wb_addr;
  logic signed [PHASE_W-1:0] phase_r;
  logic [ORB_W-1:0]          orb_r;
  status_t                   status_r;

  logic [ORB_W-1:0] lo1, hi1, lo2, hi2;
  logic             down;
  logic [IDX_W-1:0] ptr_idx, target, src, rd_addr;
  logic             rd_en;
  logic             neg;

  assign ptr_idx = ptr[IDX_W-1:0];
  assign lo1     = (a < b) ? a : b;
  assign hi1     = (a < b) ? b : a;
  assign lo2     = (c < d) ? c : d;
  assign hi2     = (c < d) ? d : c;
  assign down    = part > hole;
  assign target  = down ? IDX_W'(lt_cnt - LEN_W'(1)) : IDX_W'(lt_cnt);
  assign src     = down ? IDX_W'(ptr_idx + IDX_W'(1)) : IDX_W'(ptr_idx - IDX_W'(1));
  assign neg     = (op == OP_PHASE_DOUBLE) ? (par1 ^ par2 ^ (c < b) ^ (d < a)) : par1;
  assign rd_en   = cmd.shift_issue | cmd.scan_issue | cmd.rd_issue;

  always_comb begin
    priority if (cmd.shift_issue) begin
      rd_addr = src;
    end else if (cmd.scan_issue) begin
      rd_addr = ptr_idx;
    end else if (cmd.rd_sel == RD_LAST) begin
      rd_addr = IDX_W'(len - LEN_W'(1));
    end else begin
      rd_addr = IDX_W'(a);
    end
  end

  always_comb begin
    sts.op         = op;
    sts.full       = len == LEN_W'(MAX_ELECTRONS);
    sts.a_bad      = 32'(a) >= NUM_ORBITALS;
    sts.len_zero   = len == '0;
    sts.a_in_range = 32'(a) < 32'(len);
    sts.order_bad  = a <= rdata;
    sts.scan_done  = ptr == len;
    sts.part_bad   = 32'(part) >= NUM_ORBITALS;
    sts.hole_found = hole_found;
    sts.part_found = part_found;
    sts.shift_done = ptr_idx == target;
    sts.out_free   = !out_valid || out_ready;
  end

  // list storage, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wb_valid) begin
      mem[wb_addr] <= rdata;
    end else if (cmd.place_we) begin
      mem[target] <= part;
    end else if (cmd.append_we) begin
      mem[IDX_W'(len)] <= a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      sval      <= 1'b0;
      wb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sval     <= cmd.scan_issue;
      wb_valid <= cmd.shift_issue;
      if (cmd.len_clear) begin
        len <= '0;
      end else if (cmd.append_we) begin
        len <= LEN_W'(len + LEN_W'(1));
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= op_t'(opcode);
      a        <= orbital_a;
      b        <= orbital_b;
      c        <= orbital_c;
      d        <= orbital_d;
      status_r <= ST_OK;
      phase_r  <= '0;
      orb_r    <= '0;
    end
    if (cmd.status_we) begin
      status_r <= cmd.status_val;
    end
    if (cmd.orb_we) begin
      orb_r <= rdata;
    end
    if (cmd.phase_we) begin
      phase_r <= neg ? -2'sd1 : 2'sd1;
    end
    wb_addr <= ptr_idx;
    sidx    <= ptr_idx;

    if (cmd.scan_start) begin
      ptr        <= '0;
      hole_found <= 1'b0;
      part_found <= 1'b0;
      ih         <= '0;
      lt_cnt     <= '0;
      par1       <= 1'b0;
      par2       <= 1'b0;
      unique case (cmd.pair_sel)
        PAIR_AB: begin
          hole <= a;
          part <= b;
        end
        PAIR_CD: begin
          hole <= c;
          part <= d;
        end
        PAIR_BA: begin
          hole <= b;
          part <= a;
        end
        default: begin
          hole <= a;
          part <= b;
        end
      endcase
    end else if (cmd.scan_issue) begin
      ptr <= LEN_W'(ptr + LEN_W'(1));
    end else if (cmd.shift_init) begin
      ptr <= LEN_W'(ih);
    end else if (cmd.shift_issue) begin
      ptr <= down ? LEN_W'(ptr + LEN_W'(1)) : LEN_W'(ptr - LEN_W'(1));
    end

    // scan accumulation on returning entries
    if (sval) begin
      if (rdata == hole) begin
        hole_found <= 1'b1;
        ih         <= sidx;
      end
      if (rdata == part) begin
        part_found <= 1'b1;
      end
      if (rdata < part) begin
        lt_cnt <= LEN_W'(lt_cnt + LEN_W'(1));
      end
      if (rdata > lo1 && rdata < hi1) begin
        par1 <= ~par1;
      end
      if (rdata > lo2 && rdata < hi2) begin
        par2 <= ~par2;
      end
    end

    if (cmd.out_load) begin
      phase          <= phase_r;
      orbital_out    <= orb_r;
      occupied_count <= COUNT_W'(len);
      status         <= status_r;
    end
  end

endmodule

`default_nettype wire

/* sv/sorted_orbital_excitation_phase_unit.sv */
// per request, n list entries: a phase query scans all n entries, a single excitation
// scans them and then moves k entries (k < n) before it places the new orbital
// double excitation runs up to three such passes
// one request at a time, the next taken the cycle after the load; a held result delays it
// rst is synchronous active high: clears list length, controller state and result valid
// list storage is not cleared at reset
`default_nettype none

module sorted_orbital_excitation_phase_unit import soep_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  soep_in_if.sink    request,
  soep_out_if.source result
);

  cmd_t cmd;
  sts_t sts;

  soep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  soep_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .opcode         (request.opcode),
    .orbital_a      (request.orbital_a),
    .orbital_b      (request.orbital_b),
    .orbital_c      (request.orbital_c),
    .orbital_d      (request.orbital_d),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .phase          (result.phase),
    .orbital_out    (result.orbital_out),
    .occupied_count (result.occupied_count),
    .status         (result.status)
  );

endmodule

`default_nettype wire
